@@ hw/rtl/oale_pkg.sv @@
// ----------------------------------------------------------------------------
// Ordered list engine package
// Mode and status codes, the cell command word and the small helpers shared
// by the cell row, the match scanner and the top level.
// ----------------------------------------------------------------------------
package oale_pkg;

   // Field widths of the request and response words
   localparam int MODE_W   = 4;
   localparam int POS_W    = 7;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int FIDX_W   = 6;
   localparam int COUNT_W  = 7;

   // Width of every index and bound carried to the cells; wide enough for
   // the largest supported depth and for the position field.
   localparam int IW_MAX = 11;

   // Operation modes
   localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 4'd0;
   localparam logic [MODE_W-1:0] MODE_POP_BACK   = 4'd1;
   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 4'd2;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 4'd3;
   localparam logic [MODE_W-1:0] MODE_INSERT     = 4'd4;
   localparam logic [MODE_W-1:0] MODE_ERASE      = 4'd5;
   localparam logic [MODE_W-1:0] MODE_FIND       = 4'd6;
   localparam logic [MODE_W-1:0] MODE_MODIFY     = 4'd7;
   localparam logic [MODE_W-1:0] MODE_READ       = 4'd8;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

   // Cell command kinds
   localparam logic [1:0] CMD_NONE  = 2'd0;
   localparam logic [1:0] CMD_UP    = 2'd1;
   localparam logic [1:0] CMD_DOWN  = 2'd2;
   localparam logic [1:0] CMD_WRITE = 2'd3;

   // Command broadcast to every cell of the row
   typedef struct packed {
      logic [1:0]        kind;
      logic [IW_MAX-1:0] at;
      logic [IW_MAX-1:0] lim;
      logic [IW_MAX-1:0] cnt;
   } oale_cmd_type;

   // Lowest set bit of an eight-bit group
   function automatic logic [2:0] low_set8(input logic [7:0] bits);
      logic [2:0] r;
      r = 3'd0;
      for (int k = 7; k >= 0; k--) begin
         if (bits[k]) begin
            r = 3'(k);
         end
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/ordered_array_list_engine_core.sv @@
// ----------------------------------------------------------------------------
// Ordered list engine
// Ordered list of up to DEPTH signed 32-bit entries with push, pop, insert,
// erase, find, modify and read at a position, built as a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request word (req_mode, req_position, req_value) is taken when
//   req_valid and req_ready are both high. Every request yields exactly one
//   response word (status, found, found_index, read_value, count) on the rsp_
//   channel, in request order.
//   All operations except find are done by the cell row in the cycle of
//   acceptance: their response is valid on the next cycle, one word per
//   cycle while the receiver keeps taking them.
//   Find registers the row's match bits and then scans them eight cells per
//   cycle, so its response is registered once the scan hits a match or ends;
//   no request is taken during the scan.
//   Reset empties the list and drops any pending response. Entries past the
//   count are never read, so the cells themselves are not cleared.
//   While the receiver stalls, the response word is held in the output
//   register and a new request is taken only when that register frees up.
// ----------------------------------------------------------------------------
module ordered_array_list_engine_core
   import oale_pkg::*;
#(
   parameter int DEPTH = 64
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [MODE_W-1:0]          req_mode,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [DATA_W-1:0]   req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic                       rsp_found,
   output logic [FIDX_W-1:0]          rsp_found_index,
   output logic signed [DATA_W-1:0]   rsp_read_value,
   output logic [COUNT_W-1:0]         rsp_count
);

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   status_ff;
   logic                  found_ff;
   logic [FIDX_W-1:0]     found_index_ff;
   logic [DATA_W-1:0]     read_value_ff;
   logic [COUNT_W-1:0]    count_out_ff;

   logic                  out_free;
   logic                  accept;
   logic                  scan_busy;
   logic                  scan_done;
   logic                  scan_found;
   logic [FIDX_W-1:0]     scan_index;

   oale_cmd_type          cmd;
   logic [CW-1:0]         cnt_next;
   logic [STATUS_W-1:0]   status_now;
   logic                  start_find;
   logic                  do_read;
   logic [IW_MAX-1:0]     cnt_x;
   logic [IW_MAX-1:0]     pos_x;
   logic [IW_MAX-1:0]     slot;
   logic [DATA_W-1:0]     read_sum;
   logic [CW+COUNT_W-1:0] count_wide;

   logic [DATA_W-1:0]     cell_value [DEPTH];
   logic [DATA_W-1:0]     cell_read  [DEPTH];
   logic [DEPTH-1:0]      cell_match;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = !scan_busy && out_free;
   assign accept    = req_valid && req_ready;
   assign cnt_x     = IW_MAX'(count_ff);
   assign pos_x     = IW_MAX'(req_position);

   // Request decode against the current count
   always_comb begin
      cmd.kind   = CMD_NONE;
      cmd.at     = pos_x;
      cmd.lim    = cnt_x;
      cmd.cnt    = cnt_x;
      cnt_next   = count_ff;
      status_now = STATUS_OK;
      start_find = 1'b0;
      do_read    = 1'b0;
      slot       = '0;
      case (req_mode)
         MODE_PUSH_BACK, MODE_PUSH_FRONT, MODE_INSERT: begin
            if (req_mode == MODE_PUSH_BACK) begin
               slot = cnt_x;
            end else if (req_mode == MODE_INSERT) begin
               slot = pos_x;
            end
            if (count_ff == CW'(DEPTH)) begin
               status_now = STATUS_FULL;
            end else if (slot > cnt_x) begin
               status_now = STATUS_RANGE;
            end else begin
               cmd.kind = CMD_UP;
               cmd.at   = slot;
               cmd.lim  = cnt_x;
               cnt_next = count_ff + 1'b1;
            end
         end
         MODE_POP_BACK, MODE_POP_FRONT, MODE_ERASE: begin
            if (count_ff == '0) begin
               status_now = STATUS_EMPTY;
            end else begin
               if (req_mode == MODE_POP_BACK) begin
                  slot = cnt_x - 1'b1;
               end else if (req_mode == MODE_ERASE) begin
                  slot = pos_x;
               end
               if (slot >= cnt_x) begin
                  status_now = STATUS_RANGE;
               end else begin
                  cmd.kind = CMD_DOWN;
                  cmd.at   = slot;
                  cmd.lim  = cnt_x - 1'b1;
                  cnt_next = count_ff - 1'b1;
               end
            end
         end
         MODE_FIND: begin
            if (count_ff == '0) begin
               status_now = STATUS_EMPTY;
            end else begin
               start_find = 1'b1;
            end
         end
         MODE_MODIFY, MODE_READ: begin
            if (count_ff == '0) begin
               status_now = STATUS_EMPTY;
            end else if (pos_x >= cnt_x) begin
               status_now = STATUS_RANGE;
            end else if (req_mode == MODE_MODIFY) begin
               cmd.kind = CMD_WRITE;
            end else begin
               do_read = 1'b1;
            end
         end
         default: begin
            status_now = STATUS_OK;
         end
      endcase
      if (!accept) begin
         cmd.kind = CMD_NONE;
      end
   end

   // Row of cells, each fed by its neighbours
   for (genvar i = 0; i < DEPTH; i++) begin : g_row
      logic [DATA_W-1:0] left_v;
      logic [DATA_W-1:0] right_v;
      if (i > 0) begin : g_left
         assign left_v = cell_value[i-1];
      end else begin : g_left_end
         assign left_v = '0;
      end
      if (i < DEPTH - 1) begin : g_right
         assign right_v = cell_value[i+1];
      end else begin : g_right_end
         assign right_v = '0;
      end
      oale_cell u_cell (
         .clock       (clock),
         .cell_index  (IW_MAX'(i)),
         .cmd         (cmd),
         .wr_value    (req_value),
         .left_value  (left_v),
         .right_value (right_v),
         .value       (cell_value[i]),
         .match       (cell_match[i]),
         .read_term   (cell_read[i])
      );
   end

   always_comb begin
      read_sum = '0;
      for (int k = 0; k < DEPTH; k++) begin
         read_sum = read_sum | cell_read[k];
      end
   end

   oale_scan #(
      .DEPTH (DEPTH)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .load        (accept && start_find),
      .match_in    (cell_match),
      .take        (out_free),
      .busy        (scan_busy),
      .done        (scan_done),
      .found       (scan_found),
      .found_index (scan_index)
   );

   assign count_in   = accept ? cnt_next : count_ff;
   assign count_wide = {{COUNT_W{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if ((accept && !start_find) || (scan_done && out_free)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Response word register
   always_ff @(posedge clock) begin
      if (accept && !start_find) begin
         status_ff      <= status_now;
         found_ff       <= 1'b0;
         found_index_ff <= '0;
         read_value_ff  <= do_read ? read_sum : '0;
         count_out_ff   <= count_wide[COUNT_W-1:0];
      end else if (scan_done && out_free) begin
         status_ff      <= STATUS_OK;
         found_ff       <= scan_found;
         found_index_ff <= scan_index;
         read_value_ff  <= '0;
         count_out_ff   <= count_wide[COUNT_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_found       = found_ff;
   assign rsp_found_index = found_index_ff;
   assign rsp_read_value  = read_value_ff;
   assign rsp_count       = count_out_ff;

endmodule

@@ hw/rtl/oale_cell.sv @@
// ----------------------------------------------------------------------------
// Ordered list engine cell
// Holds one list entry. Each cycle it keeps its entry, takes its left or
// right neighbour's entry, or takes the request value, and it compares its
// entry against the search key.
// ----------------------------------------------------------------------------
module oale_cell
   import oale_pkg::*;
(
   input  logic                clock,
   input  logic [IW_MAX-1:0]   cell_index,
   input  oale_cmd_type        cmd,
   input  logic [DATA_W-1:0]   wr_value,
   input  logic [DATA_W-1:0]   left_value,
   input  logic [DATA_W-1:0]   right_value,
   output logic [DATA_W-1:0]   value,
   output logic                match,
   output logic [DATA_W-1:0]   read_term
);

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (cmd.kind)
         CMD_UP: begin
            // Entries from the gap up to the old end move one place up.
            if (cell_index == cmd.at) begin
               value_in = wr_value;
            end else if ((cell_index > cmd.at) && (cell_index <= cmd.lim)) begin
               value_in = left_value;
            end
         end
         CMD_DOWN: begin
            if ((cell_index >= cmd.at) && (cell_index < cmd.lim)) begin
               value_in = right_value;
            end
         end
         CMD_WRITE: begin
            if (cell_index == cmd.at) begin
               value_in = wr_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value     = value_ff;
   assign match     = (cell_index < cmd.cnt) && (value_ff == wr_value);
   assign read_term = (cell_index == cmd.at) ? value_ff : '0;

endmodule

@@ hw/rtl/oale_scan.sv @@
// ----------------------------------------------------------------------------
// Ordered list engine match scanner
// Takes the row's match vector and walks it eight cells per cycle, lowest
// first, to find the first matching index.
// ----------------------------------------------------------------------------
module oale_scan
   import oale_pkg::*;
#(
   parameter int DEPTH = 64
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic [DEPTH-1:0]      match_in,
   input  logic                  take,
   output logic                  busy,
   output logic                  done,
   output logic                  found,
   output logic [FIDX_W-1:0]     found_index
);

   localparam int NG = (DEPTH + 7) / 8;
   localparam int SW = NG * 8;
   localparam int GW = (NG > 1) ? $clog2(NG) : 1;
   localparam int XW = GW + 3;

   logic [SW-1:0] match_ff;
   logic [SW-1:0] match_in_pad;
   logic [GW-1:0] grp_ff;
   logic          busy_ff;
   logic          hit;
   logic          last;
   logic [XW-1:0]        index_full;
   logic [XW+FIDX_W-1:0] index_wide;

   assign match_in_pad = SW'(match_in);
   assign hit          = |match_ff[7:0];
   assign last         = (grp_ff == GW'(NG - 1));
   assign done         = busy_ff && (hit || last);
   assign index_full   = {grp_ff, low_set8(match_ff[7:0])};
   assign index_wide   = {{FIDX_W{1'b0}}, index_full};

   assign busy        = busy_ff;
   assign found       = hit;
   assign found_index = hit ? index_wide[FIDX_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (load) begin
         busy_ff <= 1'b1;
      end else if (done && take) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         match_ff <= match_in_pad;
         grp_ff   <= '0;
      end else if (busy_ff && !done) begin
         match_ff <= match_ff >> 8;
         grp_ff   <= grp_ff + 1'b1;
      end
   end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered list engine testbench
// Drives list operations into ordered_array_list_engine_core with random
// gaps and stalls on both sides. Every accepted word is fed to a predictor of
// the list, and each response word is compared field by field with the
// oldest expected one.
// ----------------------------------------------------------------------------
module testbench
   import oale_pkg::*;
;

   localparam int LIST_DEPTH   = 64;
   localparam int SETTLE_TICKS = 20;
   localparam int PLAN_PHASES  = 6;
   localparam logic [MODE_W-1:0] MODE_UNUSED = MODE_READ + 4'd1;
   localparam logic signed [DATA_W-1:0] VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef enum {PH_FILL, PH_DRAIN, PH_MIXED, PH_NOISE} phase_kind_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic                     found;
      logic [FIDX_W-1:0]        found_index;
      logic signed [DATA_W-1:0] read_value;
      logic [COUNT_W-1:0]       count;
   } list_result_type;

   class list_scoreboard;
      logic signed [DATA_W-1:0] entries[LIST_DEPTH];
      int unsigned              fill_count;
      list_result_type          awaited[$];
      int unsigned              errors;
      int unsigned              checked;

      function new();
         fill_count = 0;
         errors     = 0;
         checked    = 0;
      endfunction

      // Applies one accepted request to the list and queues the response it
      // must produce.
      function void note_request(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                                 logic signed [DATA_W-1:0] val);
         list_result_type res;
         int unsigned     ins_at;
         int unsigned     del_at;
         int unsigned     k;
         bit              hit;
         res = '0;
         hit = 1'b0;
         case (mode)
            MODE_PUSH_BACK, MODE_PUSH_FRONT, MODE_INSERT: begin
               ins_at = (mode == MODE_PUSH_BACK) ? fill_count :
                        (mode == MODE_INSERT) ? pos : 0;
               // A full list is reported before the position is looked at.
               if (fill_count >= LIST_DEPTH) begin
                  res.status = STATUS_FULL;
               end else if (ins_at > fill_count) begin
                  res.status = STATUS_RANGE;
               end else begin
                  for (k = fill_count; k > ins_at; k--) begin
                     entries[k] = entries[k - 1];
                  end
                  entries[ins_at] = val;
                  fill_count++;
               end
            end
            MODE_POP_BACK, MODE_POP_FRONT, MODE_ERASE: begin
               if (fill_count == 0) begin
                  res.status = STATUS_EMPTY;
               end else begin
                  del_at = (mode == MODE_POP_BACK) ? fill_count - 1 :
                           (mode == MODE_ERASE) ? pos : 0;
                  if (del_at >= fill_count) begin
                     res.status = STATUS_RANGE;
                  end else begin
                     for (k = del_at + 1; k < fill_count; k++) begin
                        entries[k - 1] = entries[k];
                     end
                     fill_count--;
                  end
               end
            end
            MODE_FIND: begin
               if (fill_count == 0) begin
                  res.status = STATUS_EMPTY;
               end else begin
                  for (k = 0; k < fill_count && !hit; k++) begin
                     if (entries[k] == val) begin
                        hit             = 1'b1;
                        res.found       = 1'b1;
                        res.found_index = FIDX_W'(k);
                     end
                  end
               end
            end
            MODE_MODIFY, MODE_READ: begin
               if (fill_count == 0) begin
                  res.status = STATUS_EMPTY;
               end else if (pos >= fill_count) begin
                  res.status = STATUS_RANGE;
               end else if (mode == MODE_MODIFY) begin
                  entries[pos] = val;
               end else begin
                  res.read_value = entries[pos];
               end
            end
            default: begin
            end
         endcase
         res.count = COUNT_W'(fill_count);
         awaited.push_back(res);
      endfunction

      task report(string msg);
         errors++;
         $display("MISMATCH at %0t: %s", $time, msg);
      endtask

      task check_response(list_result_type got);
         list_result_type want;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected word: status %0d count %0d", got.status,
                             got.count));
            return;
         end
         want = awaited.pop_front();
         if (got.status !== want.status)
            report($sformatf("word %0d status %0d, expected %0d", checked, got.status,
                             want.status));
         if (got.found !== want.found)
            report($sformatf("word %0d found %0d, expected %0d", checked, got.found,
                             want.found));
         if (got.found_index !== want.found_index)
            report($sformatf("word %0d found_index %0d, expected %0d", checked,
                             got.found_index, want.found_index));
         if (got.read_value !== want.read_value)
            report($sformatf("word %0d read_value %0d, expected %0d", checked,
                             got.read_value, want.read_value));
         if (got.count !== want.count)
            report($sformatf("word %0d count %0d, expected %0d", checked, got.count,
                             want.count));
         checked++;
      endtask
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [MODE_W-1:0]        req_mode;
   logic [POS_W-1:0]         req_position;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [STATUS_W-1:0]      rsp_status;
   logic                     rsp_found;
   logic [FIDX_W-1:0]        rsp_found_index;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic [COUNT_W-1:0]       rsp_count;

   list_scoreboard sb = new();
   bit quiet_phase;

   ordered_array_list_engine_core #(
      .DEPTH(LIST_DEPTH)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_found_index (rsp_found_index),
      .rsp_read_value  (rsp_read_value),
      .rsp_count       (rsp_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // During a quiet phase neither side inserts any gap.
   function automatic int unsigned draw_wait();
      return quiet_phase ? 0 : $urandom_range(0, 7);
   endfunction

   function automatic logic [MODE_W-1:0] pick_mode(phase_kind_type ph);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (ph == PH_NOISE) return MODE_W'($urandom());
      if (ph == PH_FILL && r < 70) begin
         case ($urandom_range(0, 2))
            0: return MODE_PUSH_BACK;
            1: return MODE_PUSH_FRONT;
            default: return MODE_INSERT;
         endcase
      end
      if (ph == PH_DRAIN && r < 70) begin
         case ($urandom_range(0, 2))
            0: return MODE_POP_BACK;
            1: return MODE_POP_FRONT;
            default: return MODE_ERASE;
         endcase
      end
      return MODE_W'($urandom_range(MODE_PUSH_BACK, MODE_READ));
   endfunction

   function automatic logic [POS_W-1:0] pick_position(logic [MODE_W-1:0] mode);
      int unsigned r;
      int unsigned span;
      r    = $urandom_range(0, 99);
      span = (mode == MODE_INSERT || sb.fill_count == 0) ? sb.fill_count
                                                         : sb.fill_count - 1;
      if (r < 80) return POS_W'($urandom_range(0, span));
      if (r < 90) return POS_W'(sb.fill_count + $urandom_range(0, 1));
      return POS_W'($urandom());
   endfunction

   // Small values give duplicates, so that find must pick the lowest index.
   function automatic logic signed [DATA_W-1:0] pick_value(logic [MODE_W-1:0] mode);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (mode == MODE_FIND && sb.fill_count != 0 && r < 60)
         return sb.entries[$urandom_range(0, sb.fill_count - 1)];
      if (r < 40) return DATA_W'($signed($urandom_range(0, 8)) - 4);
      if (r < 50) begin
         case ($urandom_range(0, 3))
            0: return VALUE_MAX;
            1: return VALUE_MIN;
            2: return '0;
            default: return '1;
         endcase
      end
      return DATA_W'($urandom());
   endfunction

   task automatic send_word(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                            input logic signed [DATA_W-1:0] val);
      int unsigned gap;
      gap = draw_wait();
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_mode     = mode;
      req_position = pos;
      req_value    = val;
      req_valid    = 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_request(mode, pos, val);
      @(negedge clock);
   endtask

   task automatic send_random(input phase_kind_type ph);
      logic [MODE_W-1:0] mode;
      mode = pick_mode(ph);
      if (ph == PH_NOISE)
         send_word(mode, POS_W'($urandom()), DATA_W'($urandom()));
      else
         send_word(mode, pick_position(mode), pick_value(mode));
   endtask

   task automatic wait_until_idle();
      req_valid = 1'b0;
      while (sb.awaited.size() != 0) @(negedge clock);
   endtask

   // Receiver: stalls a random number of cycles before each word.
   initial begin
      int unsigned     stall;
      list_result_type got;
      rsp_ready = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         stall = draw_wait();
         if (stall != 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got.status      = rsp_status;
         got.found       = rsp_found;
         got.found_index = rsp_found_index;
         got.read_value  = rsp_read_value;
         got.count       = rsp_count;
         sb.check_response(got);
         @(negedge clock);
      end
   end

   initial begin
      phase_kind_type plan_kind[PLAN_PHASES];
      int             plan_len[PLAN_PHASES];
      bit             plan_quiet[PLAN_PHASES];
      plan_kind    = '{PH_FILL, PH_MIXED, PH_DRAIN, PH_FILL, PH_NOISE, PH_MIXED};
      plan_len     = '{170, 110, 100, 80, 70, 70};
      plan_quiet   = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
      quiet_phase  = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_mode     = MODE_PUSH_BACK;
      req_position = '0;
      req_value    = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Operations on an empty list, then a short list built from the extremes.
      send_word(MODE_POP_BACK, '0, '0);
      send_word(MODE_POP_FRONT, '0, '0);
      send_word(MODE_ERASE, '0, '0);
      send_word(MODE_FIND, '0, '0);
      send_word(MODE_MODIFY, '0, VALUE_MAX);
      send_word(MODE_READ, '0, '0);
      send_word(MODE_INSERT, POS_W'(1), '1);
      send_word(MODE_PUSH_BACK, '0, VALUE_MAX);
      send_word(MODE_PUSH_FRONT, '1, VALUE_MIN);
      send_word(MODE_INSERT, POS_W'(2), '1);
      send_word(MODE_INSERT, POS_W'(1), '0);
      send_word(MODE_FIND, '0, '1);
      send_word(MODE_FIND, '0, DATA_W'(12345));
      send_word(MODE_READ, '1, '0);
      send_word(MODE_READ, '0, '0);
      send_word(MODE_MODIFY, POS_W'(3), DATA_W'(32'h5555_5555));
      send_word(MODE_ERASE, POS_W'(4), '0);
      send_word(MODE_ERASE, POS_W'(1), '0);
      send_word(MODE_MODIFY, '1, '1);
      send_word('1, '1, '1);
      send_word(MODE_UNUSED, '0, VALUE_MIN);
      send_word(MODE_POP_FRONT, '0, '0);
      send_word(MODE_POP_BACK, '0, '0);
      send_word(MODE_READ, POS_W'(1), '0);
      wait_until_idle();

      // Each phase ends with the sender holding off until every word is back.
      for (int p = 0; p < PLAN_PHASES; p++) begin
         quiet_phase = plan_quiet[p];
         for (int n = 0; n < plan_len[p]; n++) begin
            send_random(plan_kind[p]);
         end
         wait_until_idle();
      end
      quiet_phase = 1'b0;

      repeat (SETTLE_TICKS) @(negedge clock);
      if (sb.errors == 0) begin
         $display("PASS ordered_array_list_engine_core");
      end else begin
         $display("FAIL ordered_array_list_engine_core");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL ordered_array_list_engine_core");
      $finish;
   end

endmodule
